// ----- rtl/sdinit_pkg.sv -----
package sdinit_pkg;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 184;
    localparam int M_TUSER_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_EMMC_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SECTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_TOTAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_READY_TRIES  = 2'd3;

    // controller command flag bits
    localparam logic [15:0] F_RESP = 16'h0040;
    localparam logic [15:0] F_LONG = 16'h0080;
    localparam logic [15:0] F_CRC  = 16'h0100;
    localparam logic [15:0] F_DATA = 16'h0200;
    localparam logic [15:0] F_WAIT = 16'h2000;
    localparam logic [15:0] F_INIT = 16'h8000;

    localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
    localparam logic [5:0] CMD_SEND_OP    = 6'd1;
    localparam logic [5:0] CMD_ALL_CID    = 6'd2;
    localparam logic [5:0] CMD_SET_RCA    = 6'd3;
    localparam logic [5:0] CMD_SWITCH     = 6'd6;
    localparam logic [5:0] CMD_SELECT     = 6'd7;
    localparam logic [5:0] CMD_IF_COND    = 6'd8;
    localparam logic [5:0] CMD_READ_BLOCK = 6'd17;
    localparam logic [5:0] CMD_SD_OP_COND = 6'd41;
    localparam logic [5:0] CMD_APP        = 6'd55;

    localparam logic [31:0] ARG_IF_COND   = 32'h0000_01AA;
    localparam logic [31:0] ARG_SD_OCR    = 32'h0030_0000;
    localparam logic [31:0] ARG_EMMC_OCR  = 32'h40FF_8080;
    localparam logic [31:0] ARG_EMMC_BUS8 = 32'h03B7_0200;
    localparam logic [31:0] ARG_EMMC_RCA  = 32'h0001_0000;
    localparam logic [31:0] ARG_SD_BUS4   = 32'h0000_0002;

    localparam logic [7:0] DIV_SLOW = 8'd150;
    localparam logic [7:0] DIV_FAST = 8'd1;
    localparam logic [7:0] DIV_OFF  = 8'd0;

    localparam logic [1:0] BUS_4BIT = 2'd1;
    localparam logic [1:0] BUS_8BIT = 2'd2;

    localparam logic [15:0] EMMC_RCA = 16'd1;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_DONE  = 2'd1,
        ACT_WORD  = 2'd2,
        ACT_TMO   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        OP_CMD   = 3'd0,
        OP_CLOCK = 3'd1,
        OP_WIDTH = 3'd2,
        OP_STORE = 3'd3,
        OP_DONE  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SLOWCLK = 3'd1,
        ST_CID     = 3'd2,
        ST_ADDR    = 3'd3,
        ST_SELECT  = 3'd4,
        ST_WIDTH   = 3'd5,
        ST_READCMD = 3'd6,
        ST_FIFOTMO = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_SLOW_OFF = 4'd1,
        PH_SLOW_ON  = 4'd2,
        PH_CMD0     = 4'd3,
        PH_CMD2     = 4'd4,
        PH_CMD3     = 4'd5,
        PH_FAST_OFF = 4'd6,
        PH_FAST_ON  = 4'd7,
        PH_CMD7     = 4'd8,
        PH_POLL     = 4'd9,
        PH_APP      = 4'd10,
        PH_OCR      = 4'd11,
        PH_APPW     = 4'd12,
        PH_WIDTH    = 4'd13,
        PH_READ     = 4'd14,
        PH_DATA     = 4'd15
    } phase_t;

    typedef struct packed {
        action_t     action;
        logic        failed;
        logic [31:0] response;
        logic [31:0] fifo_word;
    } in_item_t;

    typedef struct packed {
        logic        emmc_mode;
        logic [31:0] first_sector;
        logic [31:0] sector_total;
        logic [6:0]  ready_tries;
    } cfg_t;

    typedef struct packed {
        op_t         op;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_arg;
        logic [15:0] cmd_flags;
        logic        clock_on;
        logic [7:0]  clock_divider;
        logic [1:0]  width_code;
        logic [31:0] word_index;
        logic [31:0] word_value;
        status_t     status;
        logic [31:0] sectors_done;
        logic [15:0] card_rca;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } step_t;

endpackage

// ----- rtl/sdinit_seq.sv -----
module sdinit_seq #(
    parameter int WORDS_PER_SECTOR = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  sdinit_pkg::in_item_t item,
    input  sdinit_pkg::cfg_t   cfg,
    output sdinit_pkg::step_t  step
);
    import sdinit_pkg::*;

    localparam int WCW = (WORDS_PER_SECTOR > 1) ? $clog2(WORDS_PER_SECTOR) : 1;
    localparam logic [WCW:0] WPS_LIM = (WCW + 1)'(WORDS_PER_SECTOR);

    phase_t           phase_reg, phase_next;
    logic             emmc_path_reg, emmc_path_next;
    logic             high_cap_reg, high_cap_next;
    logic [6:0]       poll_count_reg, poll_count_next;
    logic [15:0]      card_addr_reg, card_addr_next;
    logic [31:0]      sector_idx_reg, sector_idx_next;
    logic [WCW-1:0]   word_count_reg, word_count_next;
    logic [31:0]      word_ptr_reg, word_ptr_next;

    function automatic res_t mk_cmd(logic [5:0] idx, logic [31:0] arg, logic [15:0] flags);
        res_t r;
        r           = '0;
        r.op        = OP_CMD;
        r.cmd_index = idx;
        r.cmd_arg   = arg;
        r.cmd_flags = flags;
        return r;
    endfunction

    function automatic res_t mk_clk(logic on, logic [7:0] div);
        res_t r;
        r               = '0;
        r.op            = OP_CLOCK;
        r.clock_on      = on;
        r.clock_divider = div;
        return r;
    endfunction

    function automatic res_t mk_width(logic [1:0] w);
        res_t r;
        r            = '0;
        r.op         = OP_WIDTH;
        r.width_code = w;
        return r;
    endfunction

    function automatic res_t mk_fin(status_t st, logic [31:0] done, logic [15:0] rca);
        res_t r;
        r              = '0;
        r.op           = OP_DONE;
        r.status       = st;
        r.sectors_done = done;
        r.card_rca     = rca;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            emmc_path_reg  <= 1'b0;
            high_cap_reg   <= 1'b0;
            poll_count_reg <= '0;
            card_addr_reg  <= '0;
            sector_idx_reg <= '0;
            word_count_reg <= '0;
            word_ptr_reg   <= '0;
        end else if (fire) begin
            phase_reg      <= phase_next;
            emmc_path_reg  <= emmc_path_next;
            high_cap_reg   <= high_cap_next;
            poll_count_reg <= poll_count_next;
            card_addr_reg  <= card_addr_next;
            sector_idx_reg <= sector_idx_next;
            word_count_reg <= word_count_next;
            word_ptr_reg   <= word_ptr_next;
        end
    end

    always_comb begin
        logic [31:0] rca_arg;
        logic [6:0]  poll_inc;
        logic [WCW:0] wc_inc;
        logic [31:0] sidx;
        logic        do_read;
        logic        do_poll;

        rca_arg  = {card_addr_reg, 16'h0000};
        poll_inc = poll_count_reg + 7'd1;
        wc_inc   = {1'b0, word_count_reg} + (WCW + 1)'(1);
        sidx     = sector_idx_reg;
        do_read  = 1'b0;
        do_poll  = 1'b0;

        phase_next      = phase_reg;
        emmc_path_next  = emmc_path_reg;
        high_cap_next   = high_cap_reg;
        poll_count_next = poll_count_reg;
        card_addr_next  = card_addr_reg;
        sector_idx_next = sector_idx_reg;
        word_count_next = word_count_reg;
        word_ptr_next   = word_ptr_reg;
        step            = '0;

        if (item.action == ACT_START) begin
            high_cap_next   = 1'b0;
            poll_count_next = '0;
            card_addr_next  = '0;
            sector_idx_next = '0;
            word_count_next = '0;
            word_ptr_next   = '0;
            phase_next      = PH_SLOW_OFF;
            emmc_path_next  = cfg.emmc_mode;
            step.count      = 2'd1;
            step.first      = mk_clk(1'b0, DIV_OFF);
        end else if (phase_reg == PH_IDLE) begin
            step.count = 2'd0;
        end else if (item.action == ACT_DONE) begin
            step.count = 2'd1;
            case (phase_reg)
                PH_SLOW_OFF: begin
                    if (item.failed) begin
                        step.first = mk_fin(ST_SLOWCLK, sector_idx_reg, card_addr_reg);
                        phase_next = PH_IDLE;
                        emmc_path_next = 1'b0;
                    end else begin
                        phase_next = PH_SLOW_ON;
                        step.first = mk_clk(1'b1, DIV_SLOW);
                    end
                end
                PH_SLOW_ON: begin
                    if (item.failed) begin
                        step.first = mk_fin(ST_SLOWCLK, sector_idx_reg, card_addr_reg);
                        phase_next = PH_IDLE;
                        emmc_path_next = 1'b0;
                    end else begin
                        phase_next = PH_CMD0;
                        step.first = mk_cmd(CMD_GO_IDLE, 32'h0, F_INIT);
                    end
                end
                PH_CMD0: begin
                    poll_count_next = '0;
                    phase_next      = PH_POLL;
                    if (emmc_path_reg) begin
                        step.first = mk_cmd(CMD_SEND_OP, ARG_EMMC_OCR, F_RESP);
                    end else begin
                        step.first = mk_cmd(CMD_IF_COND, ARG_IF_COND, F_RESP | F_CRC);
                    end
                end
                PH_POLL: begin
                    if (emmc_path_reg) begin
                        do_poll = 1'b1;
                    end else begin
                        // CMD8 answered: card speaks the high-capacity protocol
                        high_cap_next   = ~item.failed;
                        poll_count_next = '0;
                        phase_next      = PH_APP;
                        step.first      = mk_cmd(CMD_APP, 32'h0, F_RESP | F_CRC);
                    end
                end
                PH_APP: begin
                    phase_next = PH_OCR;
                    step.first = mk_cmd(CMD_SD_OP_COND,
                                        ARG_SD_OCR | {1'b0, high_cap_reg, 30'h0}, F_RESP);
                end
                PH_OCR: begin
                    do_poll = 1'b1;
                end
                PH_CMD2: begin
                    if (item.failed) begin
                        step.first = mk_fin(ST_CID, sector_idx_reg, card_addr_reg);
                        phase_next = PH_IDLE;
                        emmc_path_next = 1'b0;
                    end else begin
                        phase_next = PH_CMD3;
                        step.first = mk_cmd(CMD_SET_RCA, emmc_path_reg ? ARG_EMMC_RCA : 32'h0,
                                            F_RESP | F_CRC);
                    end
                end
                PH_CMD3: begin
                    if (item.failed) begin
                        step.first = mk_fin(ST_ADDR, sector_idx_reg, card_addr_reg);
                        phase_next = PH_IDLE;
                        emmc_path_next = 1'b0;
                    end else begin
                        card_addr_next = emmc_path_reg ? EMMC_RCA : item.response[31:16];
                        phase_next     = PH_FAST_OFF;
                        step.first     = mk_clk(1'b0, DIV_OFF);
                    end
                end
                PH_FAST_OFF: begin
                    // skip the on update when the off update failed
                    if (!item.failed) begin
                        phase_next = PH_FAST_ON;
                        step.first = mk_clk(1'b1, DIV_FAST);
                    end else begin
                        phase_next = PH_CMD7;
                        step.first = mk_cmd(CMD_SELECT, rca_arg, F_RESP | F_CRC);
                    end
                end
                PH_FAST_ON: begin
                    phase_next = PH_CMD7;
                    step.first = mk_cmd(CMD_SELECT, rca_arg, F_RESP | F_CRC);
                end
                PH_CMD7: begin
                    if (item.failed) begin
                        step.first = mk_fin(ST_SELECT, sector_idx_reg, card_addr_reg);
                        phase_next = PH_IDLE;
                        emmc_path_next = 1'b0;
                    end else if (emmc_path_reg) begin
                        phase_next = PH_WIDTH;
                        step.first = mk_cmd(CMD_SWITCH, ARG_EMMC_BUS8, F_RESP | F_CRC);
                    end else begin
                        phase_next = PH_APPW;
                        step.first = mk_cmd(CMD_APP, rca_arg, F_RESP | F_CRC);
                    end
                end
                PH_APPW: begin
                    phase_next = PH_WIDTH;
                    step.first = mk_cmd(CMD_SWITCH, ARG_SD_BUS4, F_RESP | F_CRC);
                end
                PH_WIDTH: begin
                    if (emmc_path_reg && item.failed) begin
                        step.first = mk_fin(ST_WIDTH, sector_idx_reg, card_addr_reg);
                        phase_next = PH_IDLE;
                        emmc_path_next = 1'b0;
                    end else begin
                        step.first    = mk_width(emmc_path_reg ? BUS_8BIT : BUS_4BIT);
                        sidx          = '0;
                        word_ptr_next = '0;
                        do_read       = 1'b1;
                    end
                end
                PH_READ: begin
                    if (item.failed) begin
                        step.first = mk_fin(ST_READCMD, sector_idx_reg, card_addr_reg);
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_DATA;
                        step.count = 2'd0;
                    end
                end
                default: begin
                    step.count = 2'd0;
                end
            endcase
        end else if (phase_reg != PH_DATA) begin
            step.count = 2'd0;
        end else if (item.action == ACT_TMO) begin
            step.count = 2'd1;
            step.first = mk_fin(ST_FIFOTMO, sector_idx_reg, card_addr_reg);
            phase_next = PH_IDLE;
        end else begin
            step.count            = 2'd1;
            step.first            = '0;
            step.first.op         = OP_STORE;
            step.first.word_index = word_ptr_reg;
            step.first.word_value = item.fifo_word;
            word_ptr_next         = word_ptr_reg + 32'd1;
            if (wc_inc >= WPS_LIM) begin
                sidx    = sector_idx_reg + 32'd1;
                do_read = 1'b1;
            end else begin
                word_count_next = wc_inc[WCW-1:0];
            end
        end

        // operating-condition poll: stop on the ready bit or when tries run out
        if (do_poll) begin
            poll_count_next = poll_inc;
            if (item.response[31] || (poll_inc >= cfg.ready_tries)) begin
                phase_next = PH_CMD2;
                step.first = mk_cmd(CMD_ALL_CID, 32'h0, F_RESP | F_LONG | F_CRC);
            end else if (emmc_path_reg) begin
                phase_next = PH_POLL;
                step.first = mk_cmd(CMD_SEND_OP, ARG_EMMC_OCR, F_RESP);
            end else begin
                phase_next = PH_APP;
                step.first = mk_cmd(CMD_APP, 32'h0, F_RESP | F_CRC);
            end
        end

        // issue the next sector read, or finish once all are done
        if (do_read) begin
            sector_idx_next = sidx;
            step.count      = 2'd2;
            emmc_path_next  = 1'b0;
            if (sidx >= cfg.sector_total) begin
                step.second = mk_fin(ST_OK, sidx, card_addr_reg);
                phase_next  = PH_IDLE;
            end else begin
                word_count_next = '0;
                phase_next      = PH_READ;
                step.second     = mk_cmd(CMD_READ_BLOCK, cfg.first_sector + sidx,
                                         F_RESP | F_CRC | F_DATA | F_WAIT);
            end
        end
    end

endmodule

// ----- rtl/sdinit_outq.sv -----
module sdinit_outq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_cnt,
    input  sdinit_pkg::res_t  push_a,
    input  sdinit_pkg::res_t  push_b,
    output logic              room,
    output logic              m_valid,
    input  logic              m_ready,
    output sdinit_pkg::res_t  m_res
);
    import sdinit_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW = $clog2(DEPTH);

    res_t          mem [DEPTH];
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW:0]   count_reg, count_next;
    logic          pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_res   = mem[head_reg];
    // keep space for the two words one item may produce
    assign room    = (count_reg <= (AW + 1)'(DEPTH - 2));

    always_comb begin
        head_next  = head_reg + (pop ? AW'(1) : AW'(0));
        tail_next  = tail_reg + AW'(push_cnt);
        count_next = count_reg + (AW + 1)'(push_cnt) - (pop ? (AW + 1)'(1) : (AW + 1)'(0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[tail_reg] <= push_a;
        end
        if (push_cnt == 2'd2) begin
            mem[tail_reg + AW'(1)] <= push_b;
        end
    end

endmodule

// ----- rtl/sd_emmc_init_and_sector_read_sequencer.sv -----
// Channel   Handshake                     Payload
// s_axis    s_axis_tvalid/s_axis_tready    tuser: action; tdata: failed, response, fifo_word
// m_axis    m_axis_tvalid/m_axis_tready    tuser: op; tdata: command, clock, width, word, status
// cfg       cfg_wvalid/cfg_wready          cfg_windex, cfg_wdata (always ready)
//
// One input word per cycle while the result queue has room: a register stage takes it, the
// sequencer decides combinationally and pushes zero, one or two result words into a four-entry
// result queue. The input word is registered first; its first result word is then written into
// the result queue, and m_axis presents it from the queue head.
// Input is held back while the queue has fewer than two free entries, so items that give
// two results (width set plus first read, last word of a sector plus next read) run at the
// output rate of one word per cycle while m_axis_tready is high.
// Synchronous active-low reset returns the sequencer to idle and loads register defaults.
module sd_emmc_init_and_sector_read_sequencer #(
    parameter int WORDS_PER_SECTOR = 128
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // failed [0], response [32:1], fifo_word [64:33], zero pad [71:65]
    input  logic [sdinit_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // action [1:0]
    input  logic [sdinit_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // cmd_index [5:0], cmd_arg [37:6], cmd_flags [53:38], clock_on [54],
    // clock_divider [62:55], width_code [64:63], word_index [96:65], word_value [128:97],
    // status [131:129], sectors_done [163:132], card_rca [179:164], zero pad [183:180]
    output logic [sdinit_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // op [2:0]
    output logic [sdinit_pkg::M_TUSER_W-1:0]   m_axis_tuser,
    input  logic                               cfg_wvalid,
    output logic                               cfg_wready,
    input  logic [sdinit_pkg::CFG_IDX_W-1:0]   cfg_windex,
    input  logic [sdinit_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import sdinit_pkg::*;

    cfg_t     cfg_reg;
    logic     in_valid_reg;
    in_item_t in_item_reg;
    logic     q_room;
    logic     fire;
    step_t    step;
    res_t     out_res;

    assign cfg_wready    = 1'b1;
    assign fire          = in_valid_reg && q_room;
    assign s_axis_tready = !in_valid_reg || q_room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.emmc_mode    <= 1'b0;
            cfg_reg.first_sector <= 32'd0;
            cfg_reg.sector_total <= 32'd1;
            cfg_reg.ready_tries  <= 7'd100;
        end else if (cfg_wvalid && cfg_wready) begin
            case (cfg_windex)
                CFG_EMMC_MODE:    cfg_reg.emmc_mode    <= cfg_wdata[0];
                CFG_FIRST_SECTOR: cfg_reg.first_sector <= cfg_wdata;
                CFG_SECTOR_TOTAL: cfg_reg.sector_total <= cfg_wdata;
                CFG_READY_TRIES:  cfg_reg.ready_tries  <= cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_item_reg.action    <= action_t'(s_axis_tuser);
            in_item_reg.failed    <= s_axis_tdata[0];
            in_item_reg.response  <= s_axis_tdata[32:1];
            in_item_reg.fifo_word <= s_axis_tdata[64:33];
        end
    end

    sdinit_seq #(
        .WORDS_PER_SECTOR (WORDS_PER_SECTOR)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .step    (step)
    );

    sdinit_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (fire ? step.count : 2'd0),
        .push_a   (step.first),
        .push_b   (step.second),
        .room     (q_room),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_res    (out_res)
    );

    assign m_axis_tuser = out_res.op;
    assign m_axis_tdata = {4'b0000, out_res.card_rca, out_res.sectors_done, out_res.status,
                           out_res.word_value, out_res.word_index, out_res.width_code,
                           out_res.clock_divider, out_res.clock_on, out_res.cmd_flags,
                           out_res.cmd_arg, out_res.cmd_index};

`ifndef SYNTH
    a_result_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (step.count != 2'd0) |=> m_axis_tvalid)
        else $error("result word pushed but output not valid");

    a_start_clock: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (in_item_reg.action == ACT_START) |-> (step.count == 2'd1)
            && (step.first.op == OP_CLOCK) && !step.first.clock_on)
        else $error("start did not issue a clock-off update");

    a_pair_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (step.count == 2'd2) |-> (step.first.op == OP_WIDTH)
            || (step.first.op == OP_STORE))
        else $error("two results from an item that is neither width set nor store");
`endif

endmodule
